[hdl/mips_itype_execute_macros.svh]
// assertion macros for the mips i-type execute block
// each expects clk and rst_n to be visible where it is used
`ifndef MIPS_ITYPE_EXECUTE_MACROS_SVH
`define MIPS_ITYPE_EXECUTE_MACROS_SVH

// same-cycle implication, held off during reset
`define MITE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mips_itype_execute: same-cycle check failed");

// next-cycle implication, held off during reset
`define MITE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mips_itype_execute: next-cycle check failed");

`endif

[hdl/mite_pkg.sv]
// ----------------------------------------------------------------------------
// mite_pkg
// Shared types, opcodes and helpers of the mips i-type execute block.
// ----------------------------------------------------------------------------
package mite_pkg;

    localparam int DATA_BYTES_DEF = 1024;

    // primary opcodes of the handled i-type instructions
    typedef enum logic [5:0] {
        OP_BEQ   = 6'h04,
        OP_BNE   = 6'h05,
        OP_BGTZ  = 6'h07,
        OP_ADDI  = 6'h08,
        OP_ADDIU = 6'h09,
        OP_SLTI  = 6'h0a,
        OP_ANDI  = 6'h0c,
        OP_ORI   = 6'h0d,
        OP_NORI  = 6'h0e,
        OP_LUI   = 6'h0f,
        OP_LB    = 6'h20,
        OP_LH    = 6'h21,
        OP_LW    = 6'h23,
        OP_LBU   = 6'h24,
        OP_LHU   = 6'h25,
        OP_SB    = 6'h28,
        OP_SH    = 6'h29,
        OP_SW    = 6'h2b
    } opcode_t;

    // access size of a load or store
    typedef enum logic [1:0] {
        SZ_BYTE,
        SZ_HALF,
        SZ_WORD
    } size_t;

    // one instruction request
    typedef struct packed {
        logic [5:0]         kind;
        logic [4:0]         src_reg;
        logic [4:0]         tgt_reg;
        logic signed [15:0] immediate;
        logic [31:0]        current_pc;
    } req_t;

    // one execution result
    typedef struct packed {
        logic        reg_written;
        logic [31:0] written_value;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic        zero_register_write;
        logic        add_overflow;
        logic        address_out_of_range;
        logic        unknown_opcode;
    } rsp_t;

    // data memory access issued by the execute stage
    typedef struct packed {
        logic        rd;
        logic        wr;
        size_t       size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } mem_req_t;

    // state carried from the execute stage to the memory stage
    typedef struct packed {
        logic        do_write;
        logic        is_load;
        logic        ld_signed;
        size_t       ld_size;
        logic [31:0] value;
        logic [4:0]  tgt_reg;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic        zero_register_write;
        logic        add_overflow;
        logic        address_out_of_range;
        logic        unknown_opcode;
    } stage_t;

    // number of bytes moved by an access of the given size
    function automatic logic [2:0] size_bytes(input size_t sz);
        logic [2:0] n;
        case (sz)
            SZ_BYTE: n = 3'd1;
            SZ_HALF: n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

[hdl/mite_regfile.sv]
// ----------------------------------------------------------------------------
// mite_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Operand registers follow later writes to the register they hold.
// ----------------------------------------------------------------------------
module mite_regfile
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  rd_addr_a,
    input  logic [4:0]  rd_addr_b,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    output logic [31:0] rd_data_a,
    output logic [31:0] rd_data_b
);

    logic [31:0] rf_mem [32];
    logic [31:0] valid_reg;
    logic [4:0]  addr_a_reg;
    logic [4:0]  addr_b_reg;
    logic [31:0] data_a_reg;
    logic [31:0] data_b_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // storage, read registers with write-through and later write tracking
    // entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
            data_a_reg <= (we && waddr == rd_addr_a) ? wdata
                          : (valid_reg[rd_addr_a] ? rf_mem[rd_addr_a] : 32'h0);
            data_b_reg <= (we && waddr == rd_addr_b) ? wdata
                          : (valid_reg[rd_addr_b] ? rf_mem[rd_addr_b] : 32'h0);
        end
        else
        begin
            if (we && waddr == addr_a_reg)
            begin
                data_a_reg <= wdata;
            end
            if (we && waddr == addr_b_reg)
            begin
                data_b_reg <= wdata;
            end
        end
    end

    assign rd_data_a = data_a_reg;
    assign rd_data_b = data_b_reg;

endmodule

[hdl/mite_alu.sv]
// ----------------------------------------------------------------------------
// mite_alu
// Decode and execute of one i-type request: arithmetic, logic, compare,
// branch decision, address generation and range check.
// ----------------------------------------------------------------------------
module mite_alu
#(
    parameter int DATA_BYTES = mite_pkg::DATA_BYTES_DEF
)
(
    input  mite_pkg::req_t     req,
    input  logic [31:0]        rs,
    input  logic [31:0]        rt,
    output mite_pkg::stage_t   st,
    output mite_pkg::mem_req_t mreq
);

    logic [31:0]     simm;
    logic [31:0]     zimm;
    logic [31:0]     sum;
    logic            ovf;
    logic            unk;
    logic            writes;
    logic            zw;
    logic            in_range;
    mite_pkg::size_t size;

    assign simm = {{16{req.immediate[15]}}, req.immediate};
    assign zimm = {16'h0, req.immediate};
    assign sum  = rs + simm;
    assign ovf  = ((rs ^ sum) & (simm ^ sum)) >> 31 != 32'h0;

    // opcode classes
    always_comb
    begin
        unk = !(req.kind inside {mite_pkg::OP_ADDI, mite_pkg::OP_ADDIU, mite_pkg::OP_LW,
                                 mite_pkg::OP_LH, mite_pkg::OP_LHU, mite_pkg::OP_LB,
                                 mite_pkg::OP_LBU, mite_pkg::OP_SW, mite_pkg::OP_SH,
                                 mite_pkg::OP_SB, mite_pkg::OP_LUI, mite_pkg::OP_ANDI,
                                 mite_pkg::OP_ORI, mite_pkg::OP_NORI, mite_pkg::OP_SLTI,
                                 mite_pkg::OP_BEQ, mite_pkg::OP_BNE, mite_pkg::OP_BGTZ});
        writes = req.kind inside {mite_pkg::OP_ADDI, mite_pkg::OP_ADDIU, mite_pkg::OP_LW,
                                  mite_pkg::OP_LH, mite_pkg::OP_LHU, mite_pkg::OP_LB,
                                  mite_pkg::OP_LBU, mite_pkg::OP_LUI, mite_pkg::OP_ANDI,
                                  mite_pkg::OP_ORI, mite_pkg::OP_NORI, mite_pkg::OP_SLTI};
        zw = writes && req.tgt_reg == 5'd0;
    end

    // access size
    always_comb
    begin
        case (req.kind)
            mite_pkg::OP_LB, mite_pkg::OP_LBU, mite_pkg::OP_SB: size = mite_pkg::SZ_BYTE;
            mite_pkg::OP_LH, mite_pkg::OP_LHU, mite_pkg::OP_SH: size = mite_pkg::SZ_HALF;
            default:                                            size = mite_pkg::SZ_WORD;
        endcase
    end

    // every byte of the access must sit below the memory end
    assign in_range = ({1'b0, sum} + {30'h0, mite_pkg::size_bytes(size)})
                      <= 33'(DATA_BYTES);

    // execute
    always_comb
    begin
        st                     = '0;
        mreq                   = '0;
        st.tgt_reg             = req.tgt_reg;
        st.unknown_opcode      = unk;
        st.zero_register_write = zw;
        st.ld_size             = size;
        mreq.size              = size;
        mreq.addr              = sum;
        mreq.wdata             = rt;
        if (!unk && !zw)
        begin
            case (req.kind)
                mite_pkg::OP_ADDI:
                begin
                    if (ovf)
                    begin
                        st.add_overflow = 1'b1;
                    end
                    else
                    begin
                        st.do_write = 1'b1;
                        st.value    = sum;
                    end
                end
                mite_pkg::OP_ADDIU:
                begin
                    st.do_write = 1'b1;
                    st.value    = sum;
                end
                mite_pkg::OP_LW, mite_pkg::OP_LH, mite_pkg::OP_LHU,
                mite_pkg::OP_LB, mite_pkg::OP_LBU:
                begin
                    if (in_range)
                    begin
                        st.do_write  = 1'b1;
                        st.is_load   = 1'b1;
                        st.ld_signed = req.kind == mite_pkg::OP_LH
                                       || req.kind == mite_pkg::OP_LB;
                        mreq.rd      = 1'b1;
                    end
                    else
                    begin
                        st.address_out_of_range = 1'b1;
                    end
                end
                mite_pkg::OP_SW, mite_pkg::OP_SH, mite_pkg::OP_SB:
                begin
                    if (in_range)
                    begin
                        mreq.wr = 1'b1;
                    end
                    else
                    begin
                        st.address_out_of_range = 1'b1;
                    end
                end
                mite_pkg::OP_LUI:
                begin
                    st.do_write = 1'b1;
                    st.value    = {req.immediate, 16'h0};
                end
                mite_pkg::OP_ANDI:
                begin
                    st.do_write = 1'b1;
                    st.value    = rs & zimm;
                end
                mite_pkg::OP_ORI:
                begin
                    st.do_write = 1'b1;
                    st.value    = rs | zimm;
                end
                mite_pkg::OP_NORI:
                begin
                    st.do_write = 1'b1;
                    st.value    = ~(rs | zimm);
                end
                mite_pkg::OP_SLTI:
                begin
                    st.do_write = 1'b1;
                    st.value    = {31'h0, $signed(rs) < $signed(simm)};
                end
                mite_pkg::OP_BEQ:  st.branch_taken = rs == rt;
                mite_pkg::OP_BNE:  st.branch_taken = rs != rt;
                mite_pkg::OP_BGTZ: st.branch_taken = !rs[31] && rs != 32'h0;
                default: ;
            endcase
        end
        if (st.branch_taken)
        begin
            st.branch_target = req.current_pc + 32'd1 + simm;
        end
    end

endmodule

[hdl/mite_datamem.sv]
// ----------------------------------------------------------------------------
// mite_datamem
// Big-endian byte data memory built from four byte-wide banks, so that an
// unaligned word touches each bank once. Cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module mite_datamem
#(
    parameter int DATA_BYTES = mite_pkg::DATA_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mite_pkg::mem_req_t acc,
    output logic               busy,
    output logic [31:0]        rdata
);

    localparam int ROWS  = (DATA_BYTES + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW    = ROW_W + 2;

    logic                 clearing_reg;
    logic [ROW_W-1:0]     clr_row_reg;
    logic [2:0]           nbytes;
    logic [1:0]           lo;
    logic [1:0]           lo_reg;
    mite_pkg::size_t      size_reg;
    logic [3:0][7:0]      rd_bytes;
    logic [3:0][7:0]      acc_bytes;

    assign nbytes = mite_pkg::size_bytes(acc.size);
    assign lo     = acc.addr[1:0];
    assign busy   = clearing_reg;

    // clearing sweep, one row of all banks per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_row_reg == ROW_W'(ROWS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    // byte banks
    for (genvar L = 0; L < 4; L++)
    begin : g_lane
        logic [7:0]       bank_mem [ROWS];
        logic [1:0]       off;
        logic [AW-1:0]    baddr;
        logic [ROW_W-1:0] row;
        logic             act;
        logic [1:0]       k;
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [7:0]       wbyte;
        logic [7:0]       rd_q;

        // position of this bank's byte within the access
        assign off   = 2'(L) - lo;
        assign baddr = acc.addr[AW-1:0] + AW'(off);
        assign row   = baddr[AW-1:2];
        assign act   = {1'b0, off} < nbytes;
        assign k     = 2'(nbytes - 3'd1 - {1'b0, off});
        assign we    = clearing_reg || (acc.wr && act);
        assign waddr = clearing_reg ? clr_row_reg : row;
        assign wbyte = clearing_reg ? 8'h00 : acc.wdata[8*k +: 8];

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                bank_mem[waddr] <= wbyte;
            end
            if (acc.rd && !clearing_reg)
            begin
                rd_q <= bank_mem[row];
            end
        end

        assign rd_bytes[L] = rd_q;
    end

    // access shape of the pending load
    always_ff @(posedge clk)
    begin
        if (acc.rd && !clearing_reg)
        begin
            lo_reg   <= lo;
            size_reg <= acc.size;
        end
    end

    // gather bytes in access order
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc_bytes[i] = rd_bytes[lo_reg + 2'(i)];
        end
    end

    // right-aligned, zero-padded load word
    always_comb
    begin
        case (size_reg)
            mite_pkg::SZ_BYTE: rdata = {24'h0, acc_bytes[0]};
            mite_pkg::SZ_HALF: rdata = {16'h0, acc_bytes[0], acc_bytes[1]};
            default:           rdata = {acc_bytes[0], acc_bytes[1], acc_bytes[2], acc_bytes[3]};
        endcase
    end

endmodule

[hdl/mips_itype_execute.sv]
// ----------------------------------------------------------------------------
// mips_itype_execute
// Executes one MIPS i-type instruction per request against a 32-entry
// register file and a big-endian byte data memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one instruction request; a request is
//   taken at a clock edge where req_valid and req_ready are both high.
//   rsp_valid/rsp_ready/rsp_data carry exactly one result per request, in
//   request order.
//   The request passes the execute stage register (operands read at request),
//   the memory stage register (bank read or write) and the result register.
//   Throughput is one request per cycle while the receiver keeps up and the
//   memory is not clearing, including loads followed by users of the loaded
//   register; memory stage results are forwarded back to the execute stage.
//   After reset the data memory is swept to zero, one row of four bytes per
//   cycle over ceil(DATA_BYTES / 4) rows (256 at the default size), during
//   which req_ready stays low.
//   When the receiver stalls, the result register holds; the stages behind
//   it keep filling and req_ready drops once all three stages are full.
// ----------------------------------------------------------------------------
`include "mips_itype_execute_macros.svh"

module mips_itype_execute
#(
    parameter int DATA_BYTES = mite_pkg::DATA_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mite_pkg::req_t   req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output mite_pkg::rsp_t   rsp_data
);

    logic               s1_valid_reg;
    mite_pkg::req_t     s1_req_reg;
    logic               s2_valid_reg;
    mite_pkg::stage_t   s2_reg;
    logic               out_valid_reg;
    mite_pkg::rsp_t     out_reg;

    logic               out_en;
    logic               s2_en;
    logic               s1_en;
    logic               req_fire;
    logic               s1_fire;
    logic               mem_busy;

    logic [31:0]        rf_rs;
    logic [31:0]        rf_rt;
    logic [31:0]        rs_fwd;
    logic [31:0]        rt_fwd;
    logic               rf_we;
    logic [31:0]        s2_value;
    logic [31:0]        ld_word;
    logic [5:0]         out_outcome;

    mite_pkg::stage_t   s1_stage;
    mite_pkg::mem_req_t alu_mreq;
    mite_pkg::mem_req_t mem_acc;

    // stage enables, each stage moves when the one ahead is empty or moving
    assign out_en    = !out_valid_reg || rsp_ready;
    assign s2_en     = !s2_valid_reg || out_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign req_ready = s1_en && !mem_busy;
    assign req_fire  = req_valid && req_ready;
    assign s1_fire   = s1_valid_reg && s2_en;

    // register file, written as a result leaves the memory stage
    assign rf_we = s2_valid_reg && out_en && s2_reg.do_write;

    mite_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (req_fire),
        .rd_addr_a (req_data.src_reg),
        .rd_addr_b (req_data.tgt_reg),
        .we        (rf_we),
        .waddr     (s2_reg.tgt_reg),
        .wdata     (s2_value),
        .rd_data_a (rf_rs),
        .rd_data_b (rf_rt)
    );

    // forward the pending write of the memory stage
    always_comb
    begin
        rs_fwd = rf_rs;
        rt_fwd = rf_rt;
        if (s2_valid_reg && s2_reg.do_write)
        begin
            if (s2_reg.tgt_reg == s1_req_reg.src_reg)
            begin
                rs_fwd = s2_value;
            end
            if (s2_reg.tgt_reg == s1_req_reg.tgt_reg)
            begin
                rt_fwd = s2_value;
            end
        end
    end

    mite_alu #(.DATA_BYTES(DATA_BYTES)) u_alu
    (
        .req  (s1_req_reg),
        .rs   (rs_fwd),
        .rt   (rt_fwd),
        .st   (s1_stage),
        .mreq (alu_mreq)
    );

    // memory access happens as the request leaves the execute stage
    always_comb
    begin
        mem_acc    = alu_mreq;
        mem_acc.rd = alu_mreq.rd && s1_fire;
        mem_acc.wr = alu_mreq.wr && s1_fire;
    end

    mite_datamem #(.DATA_BYTES(DATA_BYTES)) u_datamem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (mem_acc),
        .busy  (mem_busy),
        .rdata (ld_word)
    );

    // final value of the memory stage, loads extended by size and sign
    always_comb
    begin
        s2_value = s2_reg.value;
        if (s2_reg.is_load)
        begin
            case (s2_reg.ld_size)
                mite_pkg::SZ_BYTE:
                    s2_value = {{24{s2_reg.ld_signed & ld_word[7]}}, ld_word[7:0]};
                mite_pkg::SZ_HALF:
                    s2_value = {{16{s2_reg.ld_signed & ld_word[15]}}, ld_word[15:0]};
                default:
                    s2_value = ld_word;
            endcase
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= req_fire;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg <= req_data;
        end
        if (s1_fire)
        begin
            s2_reg <= s1_stage;
        end
        if (out_en && s2_valid_reg)
        begin
            out_reg.reg_written          <= s2_reg.do_write;
            out_reg.written_value        <= s2_value;
            out_reg.branch_taken         <= s2_reg.branch_taken;
            out_reg.branch_target        <= s2_reg.branch_target;
            out_reg.zero_register_write  <= s2_reg.zero_register_write;
            out_reg.add_overflow         <= s2_reg.add_overflow;
            out_reg.address_out_of_range <= s2_reg.address_out_of_range;
            out_reg.unknown_opcode       <= s2_reg.unknown_opcode;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // outcome flags of the held result
    assign out_outcome = {out_reg.reg_written, out_reg.zero_register_write,
                          out_reg.add_overflow, out_reg.address_out_of_range,
                          out_reg.unknown_opcode, out_reg.branch_taken};

    // checks
    `MITE_ASSERT_IMP(a_no_access_while_clearing, mem_busy, !(mem_acc.rd || mem_acc.wr))
    `MITE_ASSERT_IMP(a_no_write_to_zero, rf_we, s2_reg.tgt_reg != 5'd0)
    `MITE_ASSERT_NEXT(a_write_gives_result, rf_we, out_valid_reg && out_reg.reg_written)
    `MITE_ASSERT_IMP(a_outcome_exclusive, out_valid_reg, $countones(out_outcome) <= 1)

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mips i-type execute block. A scoreboard class
// keeps its own register file and byte memory, predicts the result of every
// accepted request and checks results in order. Stimulus is a short directed
// program followed by random programs that aim loads and stores at real memory,
// under changing sender and receiver idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import mite_pkg::*;

    localparam int DATA_BYTES = DATA_BYTES_DEF;
    localparam int TIMEOUT_NS = 2_000_000;
    localparam int SETTLE_CYCLES = 8;

    // special opcode values outside the handled set
    localparam logic [5:0] KIND_SPECIAL = 6'h00;
    localparam logic [5:0] KIND_TOP     = 6'h3f;

    // scoreboard: mirrors architectural state and holds pending results
    class itype_scoreboard;
        logic [31:0] regs [32];
        logic [7:0]  mem [DATA_BYTES];
        rsp_t        pending_results [$];
        int unsigned mismatches;
        int unsigned accepted;
        int unsigned checked;
        int unsigned mem_done;
        int unsigned out_of_range;
        int unsigned taken;
        int unsigned overflows;
        int unsigned zero_dest;
        int unsigned unknown;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            foreach (mem[i])
                mem[i] = '0;
        endfunction

        function int unsigned access_bytes(logic [5:0] kind);
            case (kind)
                OP_LB, OP_LBU, OP_SB: return 1;
                OP_LH, OP_LHU, OP_SH: return 2;
                default:              return 4;
            endcase
        endfunction

        function void complain(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("tb: mismatch at %0t: %s", $time, msg);
        endfunction

        // executes one accepted request and queues its result
        function void execute_request(req_t r);
            rsp_t        res;
            logic [31:0] rs_val;
            logic [31:0] rt_val;
            logic [31:0] zimm;
            logic [31:0] simm;
            logic [31:0] addr;
            logic [31:0] val;
            int unsigned nb;
            int unsigned i;
            bit          writes_reg;
            bit          fits;
            res    = '0;
            val    = '0;
            rs_val = regs[r.src_reg];
            rt_val = regs[r.tgt_reg];
            zimm   = {16'h0000, r.immediate};
            simm   = {{16{r.immediate[15]}}, r.immediate};
            addr   = rs_val + simm;
            nb     = access_bytes(r.kind);
            fits   = ({32'h0, addr} + 64'(nb)) <= 64'(DATA_BYTES);
            accepted++;

            // which opcodes name a destination register
            case (r.kind)
                OP_BEQ, OP_BNE, OP_BGTZ, OP_SB, OP_SH, OP_SW:
                    writes_reg = 1'b0;
                OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI,
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                    writes_reg = 1'b1;
                default:
                begin
                    writes_reg = 1'b0;
                    res.unknown_opcode = 1'b1;
                end
            endcase

            // destination zero short-cuts everything else
            if (writes_reg && r.tgt_reg == 5'd0)
                res.zero_register_write = 1'b1;
            else if (!res.unknown_opcode)
            begin
                case (r.kind)
                    OP_ADDI:
                    begin
                        val = rs_val + simm;
                        if (rs_val[31] == simm[31] && val[31] != rs_val[31])
                            res.add_overflow = 1'b1;
                        else
                            res.reg_written = 1'b1;
                    end
                    OP_ADDIU:
                    begin
                        val = rs_val + simm;
                        res.reg_written = 1'b1;
                    end
                    OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW:
                    begin
                        if (fits)
                        begin
                            // big-endian gather
                            for (i = 0; i < nb; i++)
                                val = (val << 8) | {24'h0, mem[addr + i]};
                            if (r.kind == OP_LH && val[15])
                                val[31:16] = '1;
                            if (r.kind == OP_LB && val[7])
                                val[31:8] = '1;
                            res.reg_written = 1'b1;
                            mem_done++;
                        end
                        else
                            res.address_out_of_range = 1'b1;
                    end
                    OP_SB, OP_SH, OP_SW:
                    begin
                        if (fits)
                        begin
                            for (i = 0; i < nb; i++)
                                mem[addr + i] = 8'(rt_val >> (8 * (nb - 1 - i)));
                            mem_done++;
                        end
                        else
                            res.address_out_of_range = 1'b1;
                    end
                    OP_LUI:
                    begin
                        val = {r.immediate, 16'h0000};
                        res.reg_written = 1'b1;
                    end
                    OP_ANDI:
                    begin
                        val = rs_val & zimm;
                        res.reg_written = 1'b1;
                    end
                    OP_ORI:
                    begin
                        val = rs_val | zimm;
                        res.reg_written = 1'b1;
                    end
                    OP_NORI:
                    begin
                        val = ~(rs_val | zimm);
                        res.reg_written = 1'b1;
                    end
                    OP_SLTI:
                    begin
                        val = {31'b0, $signed(rs_val) < $signed(simm)};
                        res.reg_written = 1'b1;
                    end
                    OP_BEQ:
                        res.branch_taken = (rs_val == rt_val);
                    OP_BNE:
                        res.branch_taken = (rs_val != rt_val);
                    OP_BGTZ:
                        res.branch_taken = ($signed(rs_val) > 32'sd0);
                    default:
                        ;
                endcase
            end

            if (res.reg_written)
            begin
                regs[r.tgt_reg]   = val;
                res.written_value = val;
            end
            if (res.branch_taken)
            begin
                res.branch_target = r.current_pc + 32'd1 + simm;
                taken++;
            end
            if (res.address_out_of_range)
                out_of_range++;
            if (res.add_overflow)
                overflows++;
            if (res.zero_register_write)
                zero_dest++;
            if (res.unknown_opcode)
                unknown++;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                complain($sformatf("%s expected %h, got %h", name, want, got));
        endfunction

        // checks one result against the oldest pending one
        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                complain($sformatf("result %h with nothing pending", got));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("reg_written", want.reg_written, got.reg_written);
            compare_field("written_value", want.written_value, got.written_value);
            compare_field("branch_taken", want.branch_taken, got.branch_taken);
            compare_field("branch_target", want.branch_target, got.branch_target);
            compare_field("zero_register_write", want.zero_register_write,
                          got.zero_register_write);
            compare_field("add_overflow", want.add_overflow, got.add_overflow);
            compare_field("address_out_of_range", want.address_out_of_range,
                          got.address_out_of_range);
            compare_field("unknown_opcode", want.unknown_opcode, got.unknown_opcode);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_data;

    itype_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    opcode_t     mem_ops [8]      = '{OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB};
    opcode_t     alu_ops [7]      = '{OP_ADDI, OP_ADDIU, OP_LUI, OP_ANDI, OP_ORI, OP_NORI, OP_SLTI};
    opcode_t     branch_ops [3]   = '{OP_BEQ, OP_BNE, OP_BGTZ};
    logic [15:0] extreme_imms [5] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff};

    mips_itype_execute uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #2 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp_data);
    end

    // receiver: random stalls, or a counted hold-off when one is asked for
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: done, errors");
        $finish;
    end

    function automatic req_t instr(logic [5:0] kind, logic [4:0] s, logic [4:0] t,
                                   logic [15:0] imm, logic [31:0] pc = 32'd0);
        req_t r;
        r.kind       = kind;
        r.src_reg    = s;
        r.tgt_reg    = t;
        r.immediate  = imm;
        r.current_pc = pc;
        return r;
    endfunction

    // random request, loads and stores steered through the current base values
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int unsigned nb;
        logic [31:0] want;
        logic [31:0] delta;
        bit          aim;
        r.current_pc = $urandom();
        r.src_reg    = 5'($urandom_range(31));
        r.tgt_reg    = ($urandom_range(15) == 0) ? 5'd0 : 5'($urandom_range(31, 1));
        r.immediate  = 16'($urandom());
        r.kind       = 6'($urandom());
        want         = '0;
        pick         = $urandom_range(99);
        if (pick < 45)
        begin
            r.kind = mem_ops[$urandom_range(7)];
            nb     = board.access_bytes(r.kind);
            aim    = 1'b1;
            case ($urandom_range(9))
                0, 1, 2, 3: want = $urandom_range(31);
                4, 5, 6, 7: want = $urandom_range(DATA_BYTES - nb);
                8:          want = $urandom_range(DATA_BYTES + 3, DATA_BYTES - 3);
                default:    aim = 1'b0;
            endcase
            if (aim)
            begin
                delta = want - board.regs[r.src_reg];
                if ($signed(delta) >= -32768 && $signed(delta) <= 32767)
                    r.immediate = delta[15:0];
                else
                begin
                    r.src_reg   = 5'd0;
                    r.immediate = want[15:0];
                end
            end
        end
        else if (pick < 75)
        begin
            r.kind = alu_ops[$urandom_range(6)];
            case ($urandom_range(3))
                0:       r.immediate = 16'($urandom_range(15));
                1:       r.immediate = 16'(0 - $urandom_range(8));
                2:       r.immediate = extreme_imms[$urandom_range(4)];
                default: ;
            endcase
        end
        else if (pick < 90)
        begin
            r.kind    = branch_ops[$urandom_range(2)];
            r.tgt_reg = 5'($urandom_range(31));
            if ($urandom_range(2) == 0)
                r.tgt_reg = r.src_reg;
        end
        // otherwise a raw opcode, mostly outside the handled set
        return r;
    endfunction

    // offers one request and waits for it to be taken
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.execute_request(r);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_request(random_request());
    endtask

    task automatic wait_for_results();
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // directed program: extremes, every opcode, flagged cases
    task automatic run_directed();
        send_request(instr(OP_LUI,   5'd0, 5'd1, 16'h7fff));
        send_request(instr(OP_ORI,   5'd1, 5'd1, 16'hffff));
        // positive and negative addi overflow
        send_request(instr(OP_ADDI,  5'd1, 5'd2, 16'h0001));
        send_request(instr(OP_LUI,   5'd0, 5'd3, 16'h8000));
        send_request(instr(OP_ADDI,  5'd3, 5'd4, 16'hffff));
        send_request(instr(OP_ADDIU, 5'd3, 5'd4, 16'hffff));
        send_request(instr(OP_ADDI,  5'd1, 5'd0, 16'h0001));
        send_request(instr(OP_LUI,   5'd0, 5'd6, 16'h89ab));
        send_request(instr(OP_ORI,   5'd6, 5'd6, 16'hcdef));
        // big-endian word, then narrow loads with both extensions
        send_request(instr(OP_SW,    5'd0, 5'd6, 16'h0000));
        send_request(instr(OP_LH,    5'd0, 5'd7, 16'h0000));
        send_request(instr(OP_LHU,   5'd0, 5'd8, 16'h0002));
        send_request(instr(OP_LB,    5'd0, 5'd9, 16'h0003));
        send_request(instr(OP_LBU,   5'd0, 5'd10, 16'h0001));
        // top of memory: last byte fits, a half there does not
        send_request(instr(OP_SB,    5'd0, 5'd6, 16'h03ff));
        send_request(instr(OP_SH,    5'd0, 5'd6, 16'h03ff));
        send_request(instr(OP_LW,    5'd0, 5'd11, 16'h03fc));
        // address wraps below zero
        send_request(instr(OP_SW,    5'd0, 5'd6, 16'hffff));
        // load to r0 is dropped before the range check
        send_request(instr(OP_LW,    5'd0, 5'd0, 16'h7fff));
        send_request(instr(OP_ANDI,  5'd6, 5'd12, 16'hffff));
        send_request(instr(OP_NORI,  5'd0, 5'd13, 16'h0000));
        send_request(instr(OP_SLTI,  5'd3, 5'd14, 16'h0000));
        send_request(instr(OP_BEQ,   5'd0, 5'd0, 16'hffff, 32'hffff_ffff));
        send_request(instr(OP_BNE,   5'd1, 5'd3, 16'h7fff, 32'hffff_ffff));
        send_request(instr(OP_BGTZ,  5'd1, 5'd0, 16'h8000, 32'h1234_5678));
        send_request(instr(KIND_TOP, 5'd31, 5'd31, 16'hffff, 32'hffff_ffff));
        send_request(instr(KIND_SPECIAL, 5'd1, 5'd2, 16'h0000));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        send_idle_pct  = 35;
        recv_stall_pct = 75;
        hold_cycles    = 0;
        board          = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        send_random(200);

        // long receiver hold-off while the sender keeps pushing
        send_idle_pct = 0;
        hold_cycles   = 40;
        send_random(12);

        // sender pauses until everything is back
        @(negedge clk);
        req_valid <= 1'b0;
        wait_for_results();
        send_idle_pct  = 75;
        recv_stall_pct = 35;
        send_random(200);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(200);

        @(negedge clk);
        req_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending_results.size() != 0)
            board.complain($sformatf("%0d results never arrived",
                                     board.pending_results.size()));

        $display("tb: %0d requests, %0d results checked, %0d mismatches",
                 board.accepted, board.checked, board.mismatches);
        $display("tb: %0d memory accesses, %0d out of range, %0d branches taken,",
                 board.mem_done, board.out_of_range, board.taken);
        $display("tb: %0d overflows, %0d r0 writes dropped, %0d unknown opcodes",
                 board.overflows, board.zero_dest, board.unknown);
        if (board.mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

[mips_itype_execute.f]
+incdir+hdl
hdl/mite_pkg.sv
hdl/mite_regfile.sv
hdl/mite_alu.sv
hdl/mite_datamem.sv
hdl/mips_itype_execute.sv
verif/tb.sv
